>>> hw/rtl/dts_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the depth-first topological sort unit.
// No dependencies.
package dts_pkg;
    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int VW           = 6;   // vertex number width
    localparam int EAW          = 8;   // edge store address width
    localparam int ECW          = 9;   // edge count width
    localparam int EDGE_W       = 2 * VW;
    localparam int FRAME_W      = VW + ECW;

    // item kinds on the input channel
    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_SORT  = 1'b1;
endpackage

>>> hw/rtl/dts_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/dfs_topological_sort_unit.sv
`timescale 1ns / 1ps
// Top level: edge loading, depth-first walk and order emission.
// Depends on dts_pkg and dts_ram.
//
//  channel | signals                                   | dir
//  in      | i_valid o_ready i_kind i_from_vertex i_to_vertex | in
//  out     | o_valid i_ready o_vertex o_last o_edges_dropped  | out
//  cfg     | i_cfg_we i_cfg_wdata (vertex_count)        | in
//
// An edge item is taken in S_IDLE and the unit stays ready. A sort runs the edge
// store read loop (S_RD, S_EV) for each edge examined, plus root search, finish and
// stack pop per vertex, then emits each vertex through the finish RAM.
// Reset is synchronous and clears control state only; no clearing pass.
// The output register holds a vertex until the downstream side takes it.
module dfs_topological_sort_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [dts_pkg::VW-1:0] i_cfg_wdata,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_kind,
    input  logic [dts_pkg::VW-1:0] i_from_vertex,
    input  logic [dts_pkg::VW-1:0] i_to_vertex,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [dts_pkg::VW-1:0] o_vertex,
    output logic                   o_last,
    output logic                   o_edges_dropped
);
    typedef enum logic [3:0] {
        S_IDLE, S_ROOT, S_RD, S_EV, S_FIN, S_POP, S_EMRD, S_EMCAP, S_EMOUT
    } t_state;

    t_state r_state;
    logic [dts_pkg::VW-1:0]  r_count;
    logic [dts_pkg::ECW-1:0] r_edge_count;
    logic                    r_dropped;
    logic [dts_pkg::MAX_VERTICES-1:0] r_visited;
    logic [dts_pkg::VW:0]    r_root;
    logic [dts_pkg::VW-1:0]  r_cur;
    logic [dts_pkg::ECW-1:0] r_e;
    logic [dts_pkg::VW-1:0]  r_depth;
    logic [dts_pkg::VW-1:0]  r_fin;
    logic [dts_pkg::VW-1:0]  r_vertex;

    logic [dts_pkg::EDGE_W-1:0]  edge_rdata;
    logic [dts_pkg::FRAME_W-1:0] walk_rdata;
    logic [dts_pkg::VW-1:0]      fin_rdata;

    logic edge_ok, edge_we, hit, walk_we, fin_we;
    logic [dts_pkg::VW-1:0] ev_src, ev_dst;
    logic [dts_pkg::VW-1:0] walk_waddr, walk_raddr, fin_raddr;

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = (r_state == S_EMOUT);
    assign o_vertex        = r_vertex;
    assign o_last          = (r_fin == dts_pkg::VW'(1));
    assign o_edges_dropped = r_dropped;

    assign edge_ok = (i_from_vertex != '0) && (i_from_vertex <= r_count)
                  && (i_to_vertex != '0) && (i_to_vertex <= r_count)
                  && (r_edge_count != dts_pkg::ECW'(dts_pkg::MAX_EDGES));
    assign edge_we = (r_state == S_IDLE) && i_valid && (i_kind == dts_pkg::KIND_EDGE)
                  && edge_ok;

    assign ev_src = edge_rdata[dts_pkg::EDGE_W-1:dts_pkg::VW];
    assign ev_dst = edge_rdata[dts_pkg::VW-1:0];
    assign hit    = (ev_src == r_cur) && (ev_dst != '0) && (ev_dst <= r_count)
                 && !r_visited[ev_dst];

    assign walk_we    = (r_state == S_EV) && hit;
    assign walk_waddr = r_depth - dts_pkg::VW'(1);
    assign walk_raddr = r_depth - dts_pkg::VW'(2);
    assign fin_we     = (r_state == S_FIN);
    assign fin_raddr  = r_fin - dts_pkg::VW'(1);

    dts_ram #(.WIDTH(dts_pkg::EDGE_W), .DEPTH(dts_pkg::MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (r_edge_count[dts_pkg::EAW-1:0]),
        .i_wdata ({i_from_vertex, i_to_vertex}),
        .i_raddr (r_e[dts_pkg::EAW-1:0]),
        .o_rdata (edge_rdata)
    );

    dts_ram #(.WIDTH(dts_pkg::FRAME_W), .DEPTH(dts_pkg::MAX_VERTICES)) u_walk_ram (
        .i_clk   (i_clk),
        .i_we    (walk_we),
        .i_waddr (walk_waddr),
        .i_wdata ({r_cur, r_e + dts_pkg::ECW'(1)}),
        .i_raddr (walk_raddr),
        .o_rdata (walk_rdata)
    );

    dts_ram #(.WIDTH(dts_pkg::VW), .DEPTH(dts_pkg::MAX_VERTICES)) u_fin_ram (
        .i_clk   (i_clk),
        .i_we    (fin_we),
        .i_waddr (r_fin),
        .i_wdata (r_cur),
        .i_raddr (fin_raddr),
        .o_rdata (fin_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_edge_count <= '0;
            r_dropped    <= 1'b0;
            r_visited    <= '0;
            r_root       <= '0;
            r_depth      <= '0;
            r_fin        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_kind == dts_pkg::KIND_SORT) begin
                            r_visited <= '0;
                            r_root    <= (dts_pkg::VW+1)'(1);
                            r_fin     <= '0;
                            r_state   <= S_ROOT;
                        end else if (edge_ok) begin
                            r_edge_count <= r_edge_count + dts_pkg::ECW'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                    end
                end
                S_ROOT: begin
                    if (r_root > {1'b0, r_count}) begin
                        r_state <= (r_fin == '0) ? S_IDLE : S_EMRD;
                    end else if (r_visited[r_root[dts_pkg::VW-1:0]]) begin
                        r_root <= r_root + (dts_pkg::VW+1)'(1);
                    end else begin
                        r_visited[r_root[dts_pkg::VW-1:0]] <= 1'b1;
                        r_cur   <= r_root[dts_pkg::VW-1:0];
                        r_e     <= '0;
                        r_depth <= dts_pkg::VW'(1);
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // read issued at r_e; out of edges means this vertex finishes
                    r_state <= (r_e >= r_edge_count) ? S_FIN : S_EV;
                end
                S_EV: begin
                    if (hit) begin
                        r_visited[ev_dst] <= 1'b1;
                        r_cur   <= ev_dst;
                        r_e     <= '0;
                        r_depth <= r_depth + dts_pkg::VW'(1);
                    end else begin
                        r_e <= r_e + dts_pkg::ECW'(1);
                    end
                    r_state <= S_RD;
                end
                S_FIN: begin
                    r_fin <= r_fin + dts_pkg::VW'(1);
                    if (r_depth == dts_pkg::VW'(1)) begin
                        r_depth <= '0;
                        r_root  <= r_root + (dts_pkg::VW+1)'(1);
                        r_state <= S_ROOT;
                    end else begin
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    r_cur   <= walk_rdata[dts_pkg::FRAME_W-1:dts_pkg::ECW];
                    r_e     <= walk_rdata[dts_pkg::ECW-1:0];
                    r_depth <= r_depth - dts_pkg::VW'(1);
                    r_state <= S_RD;
                end
                S_EMRD:  r_state <= S_EMCAP;
                S_EMCAP: begin
                    r_vertex <= fin_rdata;
                    r_state  <= S_EMOUT;
                end
                S_EMOUT: begin
                    if (i_ready) begin
                        r_fin   <= r_fin - dts_pkg::VW'(1);
                        r_state <= (r_fin == dts_pkg::VW'(1)) ? S_IDLE : S_EMRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("input and output active together");
    a_depth_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV || r_state == S_RD) |-> (r_depth != '0))
        else $error("walk with empty stack");
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_fin != '0)) else $error("emitting with empty finish stack");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> o_ready)
        else $error("last transfer did not return to idle");
endmodule

>>> dv/dfs_topological_sort_unit_checker.sv
`timescale 1ns / 1ps
// Checker for the topological sort unit: watches the config port and both channels,
// predicts each emitted order and compares it field by field. Depends on dts_pkg.
module dfs_topological_sort_unit_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [dts_pkg::VW-1:0] i_cfg_wdata,
    input  logic                   i_valid,
    input  logic                   o_ready,
    input  logic                   i_kind,
    input  logic [dts_pkg::VW-1:0] i_from_vertex,
    input  logic [dts_pkg::VW-1:0] i_to_vertex,
    input  logic                   o_valid,
    input  logic                   i_ready,
    input  logic [dts_pkg::VW-1:0] o_vertex,
    input  logic                   o_last,
    input  logic                   o_edges_dropped,
    output int                     o_mismatches,
    output int                     o_orders_pending,
    output int                     o_vertices_seen
);
    typedef struct packed {
        logic [dts_pkg::VW-1:0] vertex;
        logic                   last;
        logic                   dropped;
    } t_order_entry;

    t_order_entry           order_q[$];
    logic [dts_pkg::VW-1:0] vcount;
    logic [dts_pkg::VW-1:0] src_mem [dts_pkg::MAX_EDGES];
    logic [dts_pkg::VW-1:0] dst_mem [dts_pkg::MAX_EDGES];
    int                     n_edges;
    logic                   dropped;

    assign o_orders_pending = order_q.size();

    function automatic bit in_span(int v, int n);
        return v >= 1 && v <= n;
    endfunction

    task automatic predict_item(logic kind, logic [dts_pkg::VW-1:0] src,
                                logic [dts_pkg::VW-1:0] dst);
        int           n;
        int           fin;
        int           depth;
        int           e;
        int           found;
        int           top;
        bit           seen [dts_pkg::MAX_VERTICES];
        int           wv   [dts_pkg::MAX_VERTICES];
        int           wn   [dts_pkg::MAX_VERTICES];
        int           done [dts_pkg::MAX_VERTICES];
        t_order_entry ent;
        n = (vcount > dts_pkg::MAX_VERTICES - 1) ? dts_pkg::MAX_VERTICES - 1 : vcount;
        if (kind == dts_pkg::KIND_EDGE) begin
            if (!in_span(src, n) || !in_span(dst, n) || n_edges >= dts_pkg::MAX_EDGES) begin
                dropped = 1'b1;
            end else begin
                src_mem[n_edges] = src;
                dst_mem[n_edges] = dst;
                n_edges++;
            end
            return;
        end
        fin = 0;
        foreach (seen[i]) seen[i] = 1'b0;
        for (int root = 1; root <= n; root++) begin
            if (seen[root]) continue;
            seen[root] = 1'b1;
            wv[0] = root;
            wn[0] = 0;
            depth = 1;
            while (depth > 0) begin
                top = depth - 1;
                e = wn[top];
                found = 0;
                while (e < n_edges) begin
                    e++;
                    if (src_mem[e-1] == wv[top] && in_span(dst_mem[e-1], n)
                            && !seen[dst_mem[e-1]]) begin
                        found = dst_mem[e-1];
                        break;
                    end
                end
                wn[top] = e;
                if (found != 0 && depth < dts_pkg::MAX_VERTICES) begin
                    seen[found] = 1'b1;
                    wv[depth] = found;
                    wn[depth] = 0;
                    depth++;
                end else begin
                    if (fin < dts_pkg::MAX_VERTICES) begin
                        done[fin] = wv[top];
                        fin++;
                    end
                    depth--;
                end
            end
        end
        // emit the finish stack top first
        for (int k = fin - 1; k >= 0; k--) begin
            ent.vertex  = dts_pkg::VW'(done[k]);
            ent.last    = (k == 0);
            ent.dropped = dropped;
            order_q.insert(order_q.size(), ent);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vcount          <= '0;
            n_edges         = 0;
            dropped         = 1'b0;
            o_mismatches    <= 0;
            o_vertices_seen <= 0;
            order_q.delete();
        end else begin
            if (i_valid && o_ready)
                predict_item(i_kind, i_from_vertex, i_to_vertex);
            if (i_cfg_we)
                vcount <= i_cfg_wdata;
            if (o_valid && i_ready) begin
                o_vertices_seen <= o_vertices_seen + 1;
                if (order_q.size() == 0) begin
                    $error("unexpected transfer: vertex %0d last %0b", o_vertex, o_last);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    t_order_entry want;
                    want = order_q.pop_front();
                    if (want.vertex !== o_vertex || want.last !== o_last
                            || want.dropped !== o_edges_dropped) begin
                        if (want.vertex !== o_vertex)
                            $error("vertex: expected %0d, got %0d", want.vertex, o_vertex);
                        if (want.last !== o_last)
                            $error("last: expected %0b, got %0b", want.last, o_last);
                        if (want.dropped !== o_edges_dropped)
                            $error("edges_dropped: expected %0b, got %0b",
                                   want.dropped, o_edges_dropped);
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

>>> dv/dfs_topological_sort_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the topological sort unit: clock, reset, edge and sort stimulus,
// watchdog and verdict. Depends on dts_pkg, the unit and its checker.
module dfs_topological_sort_unit_tb;
    localparam int WATCHDOG = 200000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [dts_pkg::VW-1:0] i_cfg_wdata = '0;
    logic                   i_valid = 1'b0;
    logic                   i_kind = 1'b0;
    logic [dts_pkg::VW-1:0] i_from_vertex = '0;
    logic [dts_pkg::VW-1:0] i_to_vertex = '0;
    logic                   i_ready = 1'b0;
    logic                   o_ready, o_valid, o_last, o_edges_dropped;
    logic [dts_pkg::VW-1:0] o_vertex;
    int                     mismatches, pending, vertices_seen;
    int                     items_sent, sorts_sent;
    int                     idle_cycles = 0;
    int                     ready_hold = 0;
    logic [dts_pkg::VW-1:0] cur_count;
    bit                     stall_mode = 1'b0;

    always #5 i_clk = ~i_clk;

    dfs_topological_sort_unit u_top (.*);

    dfs_topological_sort_unit_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .i_valid, .o_ready, .i_kind,
        .i_from_vertex, .i_to_vertex, .o_valid, .i_ready, .o_vertex, .o_last,
        .o_edges_dropped, .o_mismatches(mismatches), .o_orders_pending(pending),
        .o_vertices_seen(vertices_seen)
    );

    // downstream stalls: stretches of free flow, then short random stalls and a few long ones
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= ~stall_mode;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            i_ready    <= 1'b0;
        end else if (!stall_mode) begin
            i_ready <= 1'b1;
        end else if ($urandom_range(0, 49) == 0) begin
            ready_hold <= $urandom_range(10, 60);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAIL dfs_topological_sort_unit");
            $finish;
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    endfunction

    task automatic send_item(logic kind, logic [dts_pkg::VW-1:0] src,
                             logic [dts_pkg::VW-1:0] dst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_from_vertex <= src;
        i_to_vertex   <= dst;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (kind == dts_pkg::KIND_SORT) sorts_sent++;
    endtask

    task automatic send_random_sort();
        send_item(dts_pkg::KIND_SORT, dts_pkg::VW'($urandom_range(0, 63)),
                  dts_pkg::VW'($urandom_range(0, 63)));
    endtask

    // hold off until the unit has drained, then write the vertex count
    task automatic set_count(logic [dts_pkg::VW-1:0] value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_count   = value;
    endtask

    task automatic random_edge(bit noisy);
        logic [dts_pkg::VW-1:0] a, b;
        if (noisy || cur_count == 0) begin
            a = dts_pkg::VW'($urandom_range(0, 63));
            b = dts_pkg::VW'($urandom_range(0, 63));
        end else begin
            a = dts_pkg::VW'($urandom_range(1, cur_count));
            b = dts_pkg::VW'($urandom_range(1, cur_count));
        end
        send_item(dts_pkg::KIND_EDGE, a, b);
    endtask

    initial begin
        logic [dts_pkg::VW-1:0] cnt;
        int                     len;
        items_sent = 0;
        sorts_sent = 0;
        cur_count  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // count zero: empty sort, edge dropped
        send_item(dts_pkg::KIND_SORT, 6'd0, 6'd0);
        send_item(dts_pkg::KIND_EDGE, 6'd1, 6'd2);
        send_item(dts_pkg::KIND_SORT, 6'd63, 6'd63);
        set_count(6'd63);
        send_item(dts_pkg::KIND_EDGE, 6'd1, 6'd63);
        send_item(dts_pkg::KIND_EDGE, 6'd63, 6'd2);
        send_item(dts_pkg::KIND_EDGE, 6'd0, 6'd5);
        send_item(dts_pkg::KIND_EDGE, 6'd5, 6'd0);
        send_item(dts_pkg::KIND_EDGE, 6'd2, 6'd1);   // cycle, not detected
        send_item(dts_pkg::KIND_EDGE, 6'd40, 6'd40);
        send_item(dts_pkg::KIND_SORT, 6'd63, 6'd63);
        set_count(6'd1);
        send_item(dts_pkg::KIND_EDGE, 6'd1, 6'd1);
        send_item(dts_pkg::KIND_EDGE, 6'd2, 6'd1);
        send_item(dts_pkg::KIND_SORT, 6'd0, 6'd0);
        // lowered count skips stored edges that reach beyond it
        set_count(6'd5);
        send_item(dts_pkg::KIND_EDGE, 6'd3, 6'd4);
        send_item(dts_pkg::KIND_SORT, 6'd42, 6'd21);

        while (items_sent < 370) begin
            case ($urandom_range(0, 5))
                0:       cnt = 6'd63;
                1:       cnt = dts_pkg::VW'($urandom_range(0, 2));
                default: cnt = dts_pkg::VW'($urandom_range(3, 63));
            endcase
            set_count(cnt);
            len = $urandom_range(8, 40);
            repeat (len) begin
                if ($urandom_range(0, 6) == 0)
                    send_random_sort();
                else
                    random_edge($urandom_range(0, 7) == 0);
            end
            send_random_sort();
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Ran %0d items (%0d sorts) and checked %0d emitted vertices,",
                 items_sent, sorts_sent, vertices_seen);
        $display("covering counts 0 to 63, rejected edges, lowered counts and cyclic graphs.");
        if (mismatches == 0 && pending == 0)
            $display("PASS dfs_topological_sort_unit");
        else
            $display("FAIL dfs_topological_sort_unit");
        $finish;
    end
endmodule
